/* hw/rtl/adcfir_pkg.sv */
// Package with the shared constants, types and coefficient table of the ADC FIR filter.
`timescale 1ns / 1ps

package adcfir_pkg;

  // Filter geometry.
  localparam int TAP_COUNT  = 121;
  localparam int HIST_DEPTH = TAP_COUNT - 1;
  localparam int HALF_TAPS  = (TAP_COUNT + 1) / 2;
  localparam int TAP_W      = $clog2(TAP_COUNT);
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int IDX_W      = $clog2(HALF_TAPS);

  // Data widths.
  localparam int CODE_W    = 12;
  localparam int SAMPLE_W  = CODE_W + 1;
  localparam int COEF_BITS = 18;
  localparam int PROD_W    = SAMPLE_W + COEF_BITS;
  localparam int ACC_W     = PROD_W + TAP_W;
  localparam int OUT_W     = 20;

  // Output rounding: the sum carries 11 + (COEF_BITS - 1) fraction bits, the result 16.
  localparam int RND_SHIFT = COEF_BITS - 6;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (RND_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] OUT_MAX  = ACC_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN  = -ACC_W'(2 ** (OUT_W - 1));

  // Reset value of the offset register.
  localparam logic [CODE_W-1:0] DC_OFFSET_RESET = CODE_W'(2 ** (CODE_W - 1));

  // Rescaling of the stored Q0.17 taps to COEF_BITS.
  localparam int COEF_UP  = (COEF_BITS >= 18) ? COEF_BITS - 18 : 0;
  localparam int COEF_DN  = (COEF_BITS < 18) ? 18 - COEF_BITS : 0;
  localparam int COEF_RND = (2 ** COEF_DN) / 2;

  // Q0.17 taps c[0]..c[60]; the filter is symmetric, c[120-k] equals c[k].
  localparam int ROM_Q17 [HALF_TAPS] = '{
    530, -48, -145, -311, -534, -770, -942, -962, -767, -345,
    240, 865, 1378, 1649, 1609, 1273, 733, 133, -379, -689,
    -749, -587, -301, -26, 101, -14, -388, -947, -1536, -1958,
    -2036, -1669, -881, 177, 1256, 2085, 2455, 2292, 1690, 891,
    208, -70, 210, 1006, 2061, 2966, 3268, 2608, 846, -1858,
    -5039, -8013, -10023, -10430, -8885, -5452, -634, 4717, 9570, 12951,
    14161
  };

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } fir_state_t;

  // Coefficient for tap k, folded onto the stored half of the table.
  function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [TAP_W-1:0] tap);
    logic [IDX_W-1:0] idx;
    int q;
    int r;
    if (int'(tap) < HALF_TAPS) begin
      idx = IDX_W'(tap);
    end else begin
      idx = IDX_W'(HIST_DEPTH - int'(tap));
    end
    if (int'(idx) >= HALF_TAPS) begin
      idx = '0;
    end
    q = ROM_Q17[idx];
    r = ((q <<< COEF_UP) + COEF_RND) >>> COEF_DN;
    return COEF_BITS'(r);
  endfunction

endpackage

/* hw/rtl/adc_fir_filter_121_tap_unit.sv */
// Top level of the 121-tap FIR filter for a 12-bit ADC sample stream.
//
// Input channel: raw_sample with in_valid; the block drives in_stall. A sample
// transfers at a clock edge with in_valid high and in_stall low.
// Output channel: filtered_value with out_valid; the receiver drives out_stall.
// A result transfers at a clock edge with out_valid high and out_stall low.
// Configuration: cfg_valid, cfg_ready and dc_offset write the offset register;
// cfg_ready is always high. Write it only while the filter is idle.
// Each sample passes through one shared 13 x 18 multiply-accumulate unit, one
// tap per cycle, fed from a 120-entry history RAM with a registered read.
// out_valid rises once a transferred sample has passed the tap walk over all
// 121 taps, the drain of the read, multiply and accumulate stages, the
// rounding state and the output state. in_stall is high all that time and low
// only in the idle state, so no new sample transfers before the last result is
// loaded. The result waits in an output register; if the receiver stalls, the
// block waits in the output state with the finished result before loading it.
// Reset (rst, synchronous) clears the history valid bits, so the delay line
// reads as zeros, sets the write pointer to zero and offset to 2048.
`timescale 1ns / 1ps

module adc_fir_filter_121_tap_unit (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [adcfir_pkg::CODE_W-1:0]              raw_sample,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [adcfir_pkg::OUT_W-1:0]        filtered_value,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [adcfir_pkg::CODE_W-1:0]              dc_offset
);

  import adcfir_pkg::*;

  fir_state_t state;
  fir_state_t state_next;

  logic [CODE_W-1:0]            offset;
  logic signed [SAMPLE_W-1:0]   x;
  logic [PTR_W-1:0]             wp;
  logic [PTR_W-1:0]             rd_ptr;
  logic [TAP_W-1:0]             tap;
  logic [HIST_DEPTH-1:0]        hist_vld;

  logic                         s1_vld;
  logic                         s1_hist;
  logic                         s1_fill;
  logic signed [COEF_BITS-1:0]  s1_coef;
  logic                         p_vld;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      y_rnd;

  logic [SAMPLE_W-1:0]          ram_rdata;
  logic signed [SAMPLE_W-1:0]   mac_sample;
  logic signed [OUT_W-1:0]      y_sat;

  logic                         in_accept;
  logic                         mac_issue;
  logic                         hist_we;
  logic                         out_load;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // Offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= DC_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      offset <= dc_offset;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (tap == TAP_W'(TAP_COUNT - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_vld && !p_vld) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    mac_issue = (state == ST_MAC);
    hist_we   = (state == ST_ROUND);
    out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the offset-corrected sample and set up the tap walk.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x <= SAMPLE_W'({1'b0, raw_sample}) - SAMPLE_W'({1'b0, offset});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (in_accept) begin
      tap <= '0;
    end else if (mac_issue) begin
      tap <= tap + TAP_W'(1);
    end
  end

  // Read pointer walks backward from the newest stored sample.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_ptr <= (wp == '0) ? PTR_W'(HIST_DEPTH - 1) : wp - PTR_W'(1);
    end else if (mac_issue && tap != '0) begin
      rd_ptr <= (rd_ptr == '0) ? PTR_W'(HIST_DEPTH - 1) : rd_ptr - PTR_W'(1);
    end
  end

  // History RAM; entries never written read as zero through the valid bits.
  adcfir_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(wp),
    .wdata(x),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      wp       <= '0;
    end else if (hist_we) begin
      hist_vld[wp] <= 1'b1;
      wp           <= (wp == PTR_W'(HIST_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
    end
  end

  // First stage: coefficient lookup alongside the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= mac_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_issue) begin
      s1_hist <= (tap != '0);
      s1_fill <= hist_vld[rd_ptr];
      s1_coef <= coef_at(tap);
    end
  end

  // Second stage: the shared multiplier.
  always_comb begin
    if (!s1_hist) begin
      mac_sample = x;
    end else if (s1_fill) begin
      mac_sample = $signed(ram_rdata);
    end else begin
      mac_sample = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      prod <= PROD_W'(mac_sample * s1_coef);
    end
  end

  // Accumulator, cleared with each new sample.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      acc <= '0;
    end else if (p_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up to 2^-16 units.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      y_rnd <= (acc + RND_HALF) >>> RND_SHIFT;
    end
  end

  // Saturate to the output range.
  always_comb begin
    if (y_rnd > OUT_MAX) begin
      y_sat = OUT_W'(OUT_MAX);
    end else if (y_rnd < OUT_MIN) begin
      y_sat = OUT_W'(OUT_MIN);
    end else begin
      y_sat = OUT_W'(y_rnd);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_value <= y_sat;
    end
  end

  // The write pointer never leaves the history range.
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    int'(wp) < HIST_DEPTH)
    else $error("write pointer out of range");

  // The multiply pipeline is empty by the time the sum is rounded.
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (!s1_vld && !p_vld))
    else $error("pipeline busy at rounding");

  // An accepted sample starts the tap walk at tap zero.
  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_MAC && tap == '0))
    else $error("tap walk did not start");

  // A new result is loaded only from the output state.
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("result loaded outside output state");

endmodule

/* hw/rtl/adcfir_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module adcfir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/adc_fir_filter_121_tap_unit_test.sv */
// Self-checking testbench for the 121-tap ADC FIR filter: directed table, then random phases.
`timescale 1ns / 1ps

module adc_fir_filter_121_tap_unit_test;

  import adcfir_pkg::*;

  localparam int NTAPS      = 121;
  localparam int HALF_COUNT = 61;
  localparam int LINE_DEPTH = 120;
  localparam int OUT_HI     = 524287;
  localparam int OUT_LO     = -524288;
  localparam int RANDOM_SAMPLES = 1200;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int END_CYCLES = 200;

  // Q0.17 taps c[0]..c[60]; the other half mirrors them.
  localparam int TAP_Q17 [HALF_COUNT] = '{
    530, -48, -145, -311, -534, -770, -942, -962, -767, -345,
    240, 865, 1378, 1649, 1609, 1273, 733, 133, -379, -689,
    -749, -587, -301, -26, 101, -14, -388, -947, -1536, -1958,
    -2036, -1669, -881, 177, 1256, 2085, 2455, 2292, 1690, 891,
    208, -70, 210, 1006, 2061, 2966, 3268, 2608, 846, -1858,
    -5039, -8013, -10023, -10430, -8885, -5452, -634, 4717, 9570, 12951,
    14161
  };

  // One row of the directed table: optional offset write, then one sample.
  typedef struct packed {
    logic                    wr_offset;
    logic [CODE_W-1:0]       offset;
    logic [CODE_W-1:0]       sample;
    logic                    known;
    logic signed [OUT_W-1:0] result;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // First sample after reset at the default offset: 530 * 2047 rounded to 2^-16.
    '{1'b0, 12'd0,    12'd4095, 1'b1, 20'sd265},
    '{1'b0, 12'd0,    12'd0,    1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd2048, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd1,    1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd4094, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd2047, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd2049, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd4095, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd0,    1'b0, 20'sd0},
    // Zero offset: the largest positive difference.
    '{1'b1, 12'd0,    12'd4095, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd0,    1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd4095, 1'b0, 20'sd0},
    // Offset above the sample: differences down to -4095.
    '{1'b1, 12'd4095, 12'd0,    1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd0,    1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd4095, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd2730, 1'b0, 20'sd0},
    '{1'b1, 12'd2730, 12'd1365, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd2730, 1'b0, 20'sd0},
    '{1'b1, 12'd1365, 12'd4095, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd0,    1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd4095, 1'b0, 20'sd0},
    '{1'b1, 12'd2048, 12'd0,    1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd4095, 1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd0,    1'b0, 20'sd0},
    '{1'b0, 12'd0,    12'd2048, 1'b0, 20'sd0}
  };

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [CODE_W-1:0]       raw_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] filtered_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CODE_W-1:0]       dc_offset;

  // Predictor state: offset register, delay line and its write slot.
  logic [CODE_W-1:0]       model_offset = 12'd2048;
  logic signed [12:0]      delay_line [LINE_DEPTH];
  int                      line_ptr = 0;

  logic signed [OUT_W-1:0] pending_outputs [$];
  logic                    row_known;
  logic signed [OUT_W-1:0] row_result;
  int                      samples_sent = 0;
  int                      outputs_seen = 0;
  int                      mismatch_count = 0;
  int                      burst_left = 0;

  adc_fir_filter_121_tap_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .raw_sample     (raw_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .dc_offset      (dc_offset)
  );

  // Clock and the single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;
  end

  // Tap weight for position k of the 121-tap window.
  function automatic longint tap_weight(input int k);
    return longint'(TAP_Q17[(k < HALF_COUNT) ? k : (NTAPS - 1) - k]);
  endfunction

  // Filters one sample through the predictor and advances its delay line.
  function automatic logic signed [OUT_W-1:0] filter_sample(input logic [CODE_W-1:0] code);
    int     x;
    int     slot;
    longint acc;
    longint y;
    x = int'(code) - int'(model_offset);
    acc = tap_weight(0) * longint'(x);
    for (int k = 1; k < NTAPS; k++) begin
      slot = (line_ptr + LINE_DEPTH - k) % LINE_DEPTH;
      acc += tap_weight(k) * longint'(delay_line[slot]);
    end
    // Round half up from 2^-28 to 2^-16 units, then clamp to 20 bits.
    y = (acc + 64'sd2048) >>> 12;
    if (y > OUT_HI) begin
      y = OUT_HI;
    end
    if (y < OUT_LO) begin
      y = OUT_LO;
    end
    delay_line[line_ptr] = 13'(x);
    line_ptr = (line_ptr + 1) % LINE_DEPTH;
    return OUT_W'(y);
  endfunction

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      delay_line[i] = '0;
    end
  end

  // Scoreboard: checks output transfers, tracks offset writes and predicts each input transfer.
  always @(posedge clk) begin : scoreboard
    logic signed [OUT_W-1:0] want;
    logic signed [OUT_W-1:0] got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        outputs_seen++;
        if (pending_outputs.size() == 0) begin
          $error("filtered_value: no result expected, actual %0d", filtered_value);
          mismatch_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (filtered_value !== want) begin
            $error("filtered_value mismatch: expected %0d, actual %0d", want, filtered_value);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        model_offset = dc_offset;
      end
      if (in_valid && !in_stall) begin
        got = filter_sample(raw_sample);
        pending_outputs.push_back(row_known ? row_result : got);
      end
    end
  end

  // Offers one sample with bursty timing and waits for its transfer; called at a falling edge.
  task automatic offer_sample(input logic [CODE_W-1:0] code, input logic known,
                              input logic signed [OUT_W-1:0] result);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 250) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    raw_sample = code;
    row_known  = known;
    row_result = result;
    in_valid   = 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    burst_left--;
    samples_sent++;
  endtask

  // Writes the offset register once every pending result has drained.
  task automatic write_offset(input logic [CODE_W-1:0] value);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending_outputs.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    dc_offset = value;
    cfg_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sample source: directed table, then random phases, each at a fresh offset.
  initial begin
    int                phase_len;
    int                mode;
    int                v;
    int                n;
    logic [CODE_W-1:0] code;
    in_valid   = 1'b0;
    raw_sample = '0;
    cfg_valid  = 1'b0;
    dc_offset  = 12'd2048;
    row_known  = 1'b0;
    row_result = '0;
    @(negedge rst);
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].wr_offset) begin
        write_offset(DIR_TAB[r].offset);
      end
      offer_sample(DIR_TAB[r].sample, DIR_TAB[r].known, DIR_TAB[r].result);
    end

    n = 0;
    while (samples_sent < DIR_ROWS + RANDOM_SAMPLES) begin
      case ($urandom_range(0, 4))
        0:       write_offset(12'd0);
        1:       write_offset(12'd4095);
        2:       write_offset(12'd2048);
        default: write_offset(12'($urandom_range(0, 4095)));
      endcase
      mode = $urandom_range(0, 3);
      phase_len = $urandom_range(60, 250);
      for (int i = 0; i < phase_len && samples_sent < DIR_ROWS + RANDOM_SAMPLES; i++) begin
        case (mode)
          0: code = 12'($urandom_range(0, 4095));
          1: code = ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0;
          // Rails following the tap signs, which drives the sum toward its largest value.
          2: code = (tap_weight(n % NTAPS) >= 0) ? 12'd4095 : 12'd0;
          default: begin
            v = int'(model_offset) + $urandom_range(0, 128) - 64;
            code = (v < 0) ? 12'd0 : ((v > 4095) ? 12'd4095 : 12'(v));
          end
        endcase
        n++;
        offer_sample(code, 1'b0, '0);
      end
    end

    // Drain, then give the block time to show any stray result.
    in_valid = 1'b0;
    while (pending_outputs.size() != 0) begin
      @(negedge clk);
    end
    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("** adc_fir_filter_121_tap_unit: PASSED **");
    end else begin
      $display("** adc_fir_filter_121_tap_unit: FAILED **");
    end
    $finish;
  end

  // Result sink: stall patterns that change over time, plus one long hold-off that
  // backs the block up while the source keeps offering.
  initial begin
    int  mode;
    int  stretch;
    logic held;
    held = 1'b0;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && outputs_seen >= 400) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(20, 400);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = 1'($urandom_range(0, 1));
          2:       out_stall = ($urandom_range(0, 7) == 0);
          default: out_stall = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #40000000;
    $display("** adc_fir_filter_121_tap_unit: FAILED **");
    $finish;
  end

endmodule
